// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, constants and the shift-add-3 step for the integer-to-text path.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W        = 32;
  localparam int DIGITS         = 10;
  localparam int BCD_W          = DIGITS * 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;
  localparam int IDX_W          = $clog2(DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  // Word carried down the conversion pipeline
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } itoa_work_t;

  // One double-dabble step: correct digits >= 5, then shift one bit in
  function automatic itoa_work_t dabble_step(input itoa_work_t w);
    itoa_work_t r;
    logic [3:0] d;
    r = w;
    for (int i = 0; i < DIGITS; i++) begin
      d = r.bcd[i*4 +: 4];
      if (d >= 4'd5) begin
        r.bcd[i*4 +: 4] = d + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

endpackage

// File: rtl/itoa_abs_stage.sv
// ----------------------------------------------------------------------------
// itoa_abs_stage
// Input register: splits the sign off and forms the unsigned magnitude.
// ----------------------------------------------------------------------------
module itoa_abs_stage
  import itoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [VALUE_W-1:0] up_value,
  output logic               dn_valid,
  input  logic               dn_ready,
  output itoa_work_t         dn_data
);

  logic       vld_r;
  itoa_work_t data_r;
  itoa_work_t data_nxt;

  // Two's complement magnitude; the most negative value maps to 2^31 unsigned
  always_comb begin
    data_nxt.neg = up_value[VALUE_W-1];
    data_nxt.bin = up_value[VALUE_W-1] ? (~up_value + {{(VALUE_W-1){1'b0}}, 1'b1})
                                       : up_value;
    data_nxt.bcd = '0;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/itoa_dabble_stage.sv
// ----------------------------------------------------------------------------
// itoa_dabble_stage
// One pipeline stage of binary-to-BCD conversion, four bits per stage.
// ----------------------------------------------------------------------------
module itoa_dabble_stage
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  itoa_work_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output itoa_work_t dn_data
);

  logic       vld_r;
  itoa_work_t data_r;
  itoa_work_t data_nxt;

  // Shift BITS_PER_STAGE magnitude bits into the BCD digits
  always_comb begin
    data_nxt = up_data;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      data_nxt = dabble_step(data_nxt);
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/itoa_serializer.sv
// ----------------------------------------------------------------------------
// itoa_serializer
// Emits sign and digits of one converted number, one character per word,
// through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_serializer
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  itoa_work_t up_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_code,
  output logic       out_is_last
);

  logic             busy_r;
  logic             sign_r;
  logic [IDX_W-1:0] idx_r;
  logic [3:0]       dig_r [DIGITS];
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  logic             finishing;
  logic             load;
  logic [IDX_W-1:0] top_idx;
  logic [3:0]       cur_dig;

  // Handshake between the digit buffer and the output register
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = busy_r && out_free;
  assign finishing = emit && !sign_r && (idx_r == '0);
  assign up_ready  = !busy_r || finishing;
  assign load      = up_valid && up_ready;
  assign cur_dig   = dig_r[idx_r];

  // Most significant nonzero digit; zero keeps a single digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (up_data.bcd[i*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // Sequencing: sign first, then digits from top_idx down to 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      sign_r <= up_data.neg;
      idx_r  <= top_idx;
    end else if (emit) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else if (idx_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - {{(IDX_W-1){1'b0}}, 1'b1};
      end
    end
  end

  // Digit buffer
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < DIGITS; i++) begin
        dig_r[i] <= up_data.bcd[i*4 +: 4];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= sign_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_dig});
      out_last_r <= !sign_r && (idx_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_is_last   = out_last_r;

  // Checks
  `ASSERT_IMPLY(a_last_not_sign, out_valid_r && out_last_r, out_char_r != CHAR_MINUS, "minus sign flagged as last")
  `ASSERT_IMPLY(a_digit_range, out_valid_r && (out_char_r != CHAR_MINUS), (out_char_r >= CHAR_ZERO) && (out_char_r <= (CHAR_ZERO + {4'd0, DIGIT_MAX})), "character is not a digit")
  `ASSERT_NEXT(a_done_idle, finishing && !load, !busy_r, "buffer still busy after last digit")
  `ASSERT_IMPLY(a_load_when_free, load && busy_r, finishing, "new number loaded over unfinished text")

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// 32-bit two's complement integer to decimal ASCII text, one character per
// output word: optional '-', then digits without leading zeros, last flagged.
//
//   channel | ports                                   | dir
//   --------+-----------------------------------------+-----
//   in      | in_valid, in_ready, in_value[31:0]      | in
//   out     | out_valid, out_ready, out_char_code[7:0], | out
//           | out_is_last                             |
//
// A new word can enter every cycle unless the stages are backed up; the
// output runs one character per cycle while out_ready is high, so a number
// takes 1 to 11 words, sign included. A word passes the input register, eight
// double-dabble stages of four bits each, the digit buffer and the output
// register. Reset clears all valid bits; payload registers are not reset.
// A stall on out_ready backs up through the stages without losing a word.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import itoa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char_code,
  output logic                out_is_last
);

  logic       st_valid [DABBLE_STAGES+1];
  logic       st_ready [DABBLE_STAGES+1];
  itoa_work_t st_data  [DABBLE_STAGES+1];

  // Sign split and magnitude
  itoa_abs_stage u_abs (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_value ($unsigned(in_value)),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  // Binary-to-BCD pipeline
  for (genvar s = 0; s < DABBLE_STAGES; s++) begin : g_dabble
    itoa_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[s]),
      .up_ready (st_ready[s]),
      .up_data  (st_data[s]),
      .dn_valid (st_valid[s+1]),
      .dn_ready (st_ready[s+1]),
      .dn_data  (st_data[s+1])
    );
  end

  // Character output
  itoa_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (st_valid[DABBLE_STAGES]),
    .up_ready      (st_ready[DABBLE_STAGES]),
    .up_data       (st_data[DABBLE_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule
